// File: design/cbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types, constants and helpers for the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

	localparam int CBC_RAM_BYTES      = 32768;
	localparam int CBC_RAM_BANK_BYTES = 8192;
	localparam int CBC_RAM_BANK_AW    = $clog2(CBC_RAM_BANK_BYTES);

	// result source codes
	typedef enum logic [1:0] {
		SRC_ROM      = 2'd0,
		SRC_RAM      = 2'd1,
		SRC_UNMAPPED = 2'd2,
		SRC_BEYOND   = 2'd3
	} source_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_WIDE_BANK_MODE = 2'd0,
		CFG_ROM_BANKS      = 2'd1,
		CFG_RAM_SIZE_CODE  = 2'd2
	} cfg_index_t;

	// RAM size codes
	localparam logic [2:0] RAM_CODE_NONE = 3'd0;
	localparam logic [2:0] RAM_CODE_2K   = 3'd1;
	localparam logic [2:0] RAM_CODE_8K   = 3'd2;
	localparam logic [2:0] RAM_CODE_32K  = 3'd3;
	localparam logic [2:0] RAM_CODE_128K = 3'd4;

	localparam logic [6:0] ROM_BANK_MASK_WIDE   = 7'h7f;
	localparam logic [6:0] ROM_BANK_MASK_NARROW = 7'h1f;
	localparam logic [7:0] OPEN_BUS_BYTE        = 8'hff;

	// nominal RAM size in bytes; undefined codes mean no RAM
	function automatic logic [17:0] ram_size_bytes(input logic [2:0] code);
		logic [17:0] sz;
		case (code)
			RAM_CODE_2K:   sz = 18'd2048;
			RAM_CODE_8K:   sz = 18'd8192;
			RAM_CODE_32K:  sz = 18'd32768;
			RAM_CODE_128K: sz = 18'd131072;
			default:       sz = 18'd0;
		endcase
		return sz;
	endfunction

endpackage

// File: design/cbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_ram
// Cartridge RAM: one port, registered read, zero-fill pass after reset.
// ----------------------------------------------------------------------------
module cbc_ram import cbc_pkg::*; #(
	parameter int RAM_BYTES = CBC_RAM_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic                         wr_en,
	input  logic [$clog2(RAM_BYTES)-1:0] addr,
	input  logic [7:0]                   wdata,
	output logic [7:0]                   rdata,
	output logic                         busy
);

	localparam int AW = $clog2(RAM_BYTES);

	logic [7:0]    mem [RAM_BYTES];
	logic [AW-1:0] clr_addr_q;
	logic          clearing_q;
	logic [7:0]    rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(RAM_BYTES - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= 8'h00;
		end else if (wr_en) begin
			mem[addr] <= wdata;
		end
	end

	// read data only moves on a read, so it holds while the result is stalled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clearing_q;

endmodule

// File: design/cartridge_bank_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_controller
// Bank controller for a cartridge bus: ROM bank translation, RAM banking and
// bank register writes, one bus access per beat.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  in       | in_valid / in_ready       | command, address, write_data
//  out      | out_valid / out_ready     | source, rom_address, read_data
//  cfg      | cfg_we (no wait)          | cfg_index, cfg_data
//
//  One beat accepted per cycle while in_ready is high; a beat passes the
//  input register, then the result register next to the RAM read port, and
//  out_valid rises once it reaches the result register.
//  After reset the RAM is zero-filled one byte per cycle with in_ready low;
//  cfg writes are taken during that time.
//  An out stall holds the result register and backs up into the input stage.
// ----------------------------------------------------------------------------
module cartridge_bank_controller import cbc_pkg::*; #(
	parameter int RAM_BYTES = CBC_RAM_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  source,
	output logic [20:0] rom_address,
	output logic [7:0]  read_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int AW = $clog2(RAM_BYTES);

	// configuration
	logic       wide_mode_q;
	logic [7:0] rom_banks_q;
	logic [2:0] ram_code_q;

	// bank registers
	logic [6:0] rom_bank_q;
	logic [1:0] ram_bank_q;

	// input stage
	logic        valid_s1;
	logic        cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;

	// result stage
	logic        valid_s2;
	source_t     source_s2;
	logic [20:0] rom_addr_s2;
	logic        ram_rd_s2;

	logic        fire_s1;
	logic        ram_busy;
	logic [7:0]  ram_rdata;

	logic [17:0] usable_size;
	logic [17:0] nominal_size;
	logic [14:0] ram_off;
	logic        ram_win;
	source_t     src_c;
	logic [20:0] rom_addr_c;
	logic        ram_rd_c;
	logic        ram_wr_c;
	logic        set_ram_bank_c;
	logic        set_rom_bank_c;
	logic [6:0]  bank_masked;
	logic [6:0]  bank_next;

	function automatic logic [6:0] wrap_mask(input logic wide, input logic [6:0] v);
		return v & (wide ? ROM_BANK_MASK_WIDE : ROM_BANK_MASK_NARROW);
	endfunction

	assign fire_s1  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !ram_busy && (!valid_s1 || fire_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode_q <= 1'b0;
			rom_banks_q <= 8'd2;
			ram_code_q  <= RAM_CODE_NONE;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_WIDE_BANK_MODE: wide_mode_q <= cfg_data[0];
				CFG_ROM_BANKS:      rom_banks_q <= cfg_data;
				CFG_RAM_SIZE_CODE:  ram_code_q  <= cfg_data[2:0];
				default:            ;
			endcase
		end
	end

	// ---- decode of the beat in the input stage
	assign nominal_size = ram_size_bytes(ram_code_q);
	assign usable_size  = (nominal_size > 18'(RAM_BYTES)) ? 18'(RAM_BYTES) : nominal_size;
	assign ram_off      = {ram_bank_q, addr_s1[CBC_RAM_BANK_AW-1:0]};
	assign ram_win      = (addr_s1[15:13] == 3'b101);

	assign bank_masked = wrap_mask(wide_mode_q, wdata_s1[6:0]);
	assign bank_next   = (bank_masked == 7'd0 || {1'b0, bank_masked} >= rom_banks_q)
	                     ? 7'd1 : bank_masked;

	always_comb begin
		src_c          = SRC_UNMAPPED;
		rom_addr_c     = 21'd0;
		ram_rd_c       = 1'b0;
		ram_wr_c       = 1'b0;
		set_ram_bank_c = 1'b0;
		set_rom_bank_c = 1'b0;
		if (usable_size != 18'd0 && ram_win) begin
			if ({3'b000, ram_off} >= usable_size) begin
				src_c = SRC_BEYOND;
			end else begin
				src_c    = SRC_RAM;
				ram_wr_c = cmd_s1;
				ram_rd_c = !cmd_s1;
			end
		end else if (!addr_s1[15]) begin
			src_c = SRC_ROM;
			if (cmd_s1) begin
				set_ram_bank_c = (addr_s1[14:13] == 2'b10);
				set_rom_bank_c = (addr_s1[14:13] == 2'b01);
			end else if (!addr_s1[14]) begin
				rom_addr_c = {7'd0, addr_s1[13:0]};
			end else begin
				rom_addr_c = {rom_bank_q, addr_s1[13:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= 7'd1;
			ram_bank_q <= 2'd0;
		end else if (fire_s1) begin
			if (set_rom_bank_c) begin
				rom_bank_q <= bank_next;
			end
			if (set_ram_bank_c) begin
				ram_bank_q <= wdata_s1[1:0];
			end
		end
	end

	// ---- pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= command;
			addr_s1  <= address;
			wdata_s1 <= write_data;
		end
		if (fire_s1) begin
			source_s2   <= src_c;
			rom_addr_s2 <= rom_addr_c;
			ram_rd_s2   <= ram_rd_c;
		end
	end

	cbc_ram #(
		.RAM_BYTES(RAM_BYTES)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (fire_s1 && ram_rd_c),
		.wr_en  (fire_s1 && ram_wr_c),
		.addr   (ram_off[AW-1:0]),
		.wdata  (wdata_s1),
		.rdata  (ram_rdata),
		.busy   (ram_busy)
	);

	assign out_valid   = valid_s2;
	assign source      = source_s2;
	assign rom_address = rom_addr_s2;
	assign read_data   = ram_rd_s2 ? ram_rdata : OPEN_BUS_BYTE;

endmodule

// File: test/cbc_bus_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_bus_checker
// Watches the bus, config and result channels of the cartridge bank
// controller. Keeps its own bank registers and RAM image, decodes every
// accepted access, and compares each result beat with the oldest decode.
// ----------------------------------------------------------------------------
module cbc_bus_checker import cbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        command,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  source,
	input  logic [20:0] rom_address,
	input  logic [7:0]  read_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          outstanding
);

	typedef struct {
		logic [15:0] addr;
		logic        wr;
		source_t     src;
		logic [20:0] rom_addr;
		logic [7:0]  rdata;
	} bus_reply_t;

	logic       wide_mode;
	logic [7:0] rom_bank_count;
	logic [2:0] ram_code;
	logic [6:0] rom_bank;
	logic [1:0] ram_bank;
	logic [7:0] ram_image [CBC_RAM_BYTES];
	bus_reply_t replies_due [$];
	int         mismatches;

	// bytes reachable through the RAM window; capped at what is built in
	function automatic int ram_window_bytes(input logic [2:0] code);
		int n;
		case (code)
			RAM_CODE_2K:   n = 2048;
			RAM_CODE_8K:   n = 8192;
			RAM_CODE_32K:  n = 32768;
			RAM_CODE_128K: n = 131072;
			default:       n = 0;
		endcase
		return (n > CBC_RAM_BYTES) ? CBC_RAM_BYTES : n;
	endfunction

	// decodes one access and applies its side effects to the bank registers
	// and the RAM image
	function automatic bus_reply_t decode_access(input logic wr, input logic [15:0] addr,
			input logic [7:0] data);
		bus_reply_t r;
		int         span;
		int         offs;
		logic [6:0] bank;
		span       = ram_window_bytes(ram_code);
		r.addr     = addr;
		r.wr       = wr;
		r.src      = SRC_UNMAPPED;
		r.rom_addr = '0;
		r.rdata    = OPEN_BUS_BYTE;
		if (span > 0 && addr >= 16'hA000 && addr < 16'hC000) begin
			offs = int'(ram_bank) * CBC_RAM_BANK_BYTES + int'(addr - 16'hA000);
			if (offs >= span) begin
				r.src = SRC_BEYOND;
			end else begin
				r.src = SRC_RAM;
				if (wr)
					ram_image[offs] = data;
				else
					r.rdata = ram_image[offs];
			end
		end else if (addr < 16'h8000) begin
			r.src = SRC_ROM;
			if (wr) begin
				if (addr >= 16'h4000 && addr < 16'h6000) begin
					ram_bank = data[1:0];
				end else if (addr >= 16'h2000 && addr < 16'h4000) begin
					bank = data[6:0] & (wide_mode ? ROM_BANK_MASK_WIDE : ROM_BANK_MASK_NARROW);
					if (bank == '0 || {1'b0, bank} >= rom_bank_count)
						bank = 7'd1;
					rom_bank = bank;
				end
			end else if (addr < 16'h4000) begin
				r.rom_addr = 21'(addr);
			end else begin
				r.rom_addr = {rom_bank, addr[13:0]};
			end
		end
		return r;
	endfunction

	task automatic report(input string what);
		mismatches++;
		$display("%0t ns mismatch: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bus_reply_t want;
		if (!arst_n) begin
			wide_mode      = 1'b0;
			rom_bank_count = 8'd2;
			ram_code       = RAM_CODE_NONE;
			rom_bank       = 7'd1;
			ram_bank       = 2'd0;
			for (int i = 0; i < CBC_RAM_BYTES; i++)
				ram_image[i] = 8'h00;
			replies_due.delete();
			mismatches = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					report($sformatf("result beat (source %0d) with no access outstanding",
						source));
				end else begin
					want = replies_due.pop_front();
					if (source !== want.src)
						report($sformatf("%s %h: source %0d, want %0d",
							want.wr ? "wr" : "rd", want.addr, source, want.src));
					if (rom_address !== want.rom_addr)
						report($sformatf("%s %h: rom_address %h, want %h",
							want.wr ? "wr" : "rd", want.addr, rom_address, want.rom_addr));
					if (read_data !== want.rdata)
						report($sformatf("%s %h: read_data %h, want %h",
							want.wr ? "wr" : "rd", want.addr, read_data, want.rdata));
				end
			end
			if (in_valid && in_ready)
				replies_due.push_back(decode_access(command, address, write_data));
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDE_BANK_MODE: wide_mode      = cfg_data[0];
					CFG_ROM_BANKS:      rom_bank_count = cfg_data;
					CFG_RAM_SIZE_CODE:  ram_code       = cfg_data[2:0];
					default: ;
				endcase
			end
			fail_count  <= mismatches;
			outstanding <= replies_due.size();
		end
	end

endmodule

// File: test/tb_cartridge_bank_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_controller
// Drives bus accesses and bank settings into the cartridge bank controller
// under random source gaps and result stalls; the bus checker beside the
// block predicts every result and counts mismatches for the verdict here.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_controller;
	import cbc_pkg::*;

	localparam logic CMD_READ        = 1'b0;
	localparam logic CMD_WRITE       = 1'b1;
	localparam int   RANDOM_ACCESSES = 1750;
	localparam int   BANK_SETUPS     = 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  source;
	logic [20:0] rom_address;
	logic [7:0]  read_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	int          fail_count;
	int          outstanding;
	int          gap_pct;
	int          stall_pct;

	cartridge_bank_controller dut (.*);

	cbc_bus_checker u_bus_check (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99, 0) >= stall_pct);

	initial begin
		#(10_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_banking(input logic wide, input logic [7:0] banks,
			input logic [2:0] code);
		write_reg(CFG_WIDE_BANK_MODE, {7'd0, wide});
		write_reg(CFG_ROM_BANKS, banks);
		write_reg(CFG_RAM_SIZE_CODE, {5'd0, code});
		cfg_we <= 1'b0;
	endtask

	// valid stays up after a beat unless a gap follows
	task automatic send_access(input logic wr, input logic [15:0] addr,
			input logic [7:0] data);
		while ($urandom_range(99, 0) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= wr;
		address    <= addr;
		write_data <= data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly bank edges and the 2 KB boundary so reads hit earlier writes
	function automatic logic [15:0] ram_window_addr();
		case ($urandom_range(3, 0))
			0:       return 16'hA000 + 16'($urandom_range(31, 0));
			1:       return 16'hBFE0 + 16'($urandom_range(31, 0));
			2:       return 16'hA7F0 + 16'($urandom_range(31, 0));
			default: return 16'hA000 + 16'($urandom_range(16'h1FFF, 0));
		endcase
	endfunction

	task automatic random_access();
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  data;
		int          pick;
		pick = $urandom_range(99, 0);
		data = 8'($urandom);
		wr   = 1'($urandom);
		if (pick < 14) begin
			wr   = CMD_READ;
			addr = 16'($urandom_range(16'h3FFF, 0));
		end else if (pick < 30) begin
			wr   = CMD_READ;
			addr = 16'h4000 + 16'($urandom_range(16'h3FFF, 0));
		end else if (pick < 40) begin
			wr   = CMD_WRITE;
			addr = 16'h2000 + 16'($urandom_range(16'h1FFF, 0));
		end else if (pick < 48) begin
			wr   = CMD_WRITE;
			addr = 16'h4000 + 16'($urandom_range(16'h1FFF, 0));
		end else if (pick < 70) begin
			wr   = CMD_WRITE;
			addr = ram_window_addr();
		end else if (pick < 92) begin
			wr   = CMD_READ;
			addr = ram_window_addr();
		end else begin
			addr = 16'($urandom);
		end
		send_access(wr, addr, data);
	endtask

	initial begin
		int issued;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		command    = CMD_READ;
		address    = '0;
		write_data = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_WIDE_BANK_MODE;
		cfg_data   = '0;
		gap_pct    = 27;
		stall_pct  = 52;
		issued     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// wide mask, full ROM, 32 KB RAM; taken while the RAM clears
		load_banking(1'b1, 8'd128, RAM_CODE_32K);
		send_access(CMD_READ, 16'h0000, 8'h00);
		send_access(CMD_READ, 16'h3FFF, 8'hFF);
		send_access(CMD_READ, 16'h4000, 8'h00);
		send_access(CMD_WRITE, 16'h2000, 8'h00);
		send_access(CMD_WRITE, 16'h3FFF, 8'hFF);
		send_access(CMD_READ, 16'h7FFF, 8'h00);
		send_access(CMD_WRITE, 16'h2000, 8'h80);
		send_access(CMD_READ, 16'h4000, 8'hFF);
		send_access(CMD_WRITE, 16'h4000, 8'hFF);
		send_access(CMD_WRITE, 16'hBFFF, 8'hA5);
		send_access(CMD_READ, 16'hBFFF, 8'h00);
		send_access(CMD_WRITE, 16'h5FFF, 8'h00);
		send_access(CMD_READ, 16'hA000, 8'h00);
		send_access(CMD_WRITE, 16'hA000, 8'hFF);
		send_access(CMD_READ, 16'hA000, 8'h00);
		send_access(CMD_WRITE, 16'h0000, 8'h12);
		send_access(CMD_WRITE, 16'h6000, 8'h01);
		send_access(CMD_READ, 16'h8000, 8'h00);
		send_access(CMD_WRITE, 16'h9FFF, 8'h5A);
		send_access(CMD_WRITE, 16'hFFFF, 8'hFF);
		drain();

		// narrow mask, two banks, 2 KB RAM: bank clamp and beyond-size window
		load_banking(1'b0, 8'd2, RAM_CODE_2K);
		send_access(CMD_WRITE, 16'h2000, 8'hFF);
		send_access(CMD_READ, 16'h7FFF, 8'h00);
		send_access(CMD_READ, 16'hA7FF, 8'h00);
		send_access(CMD_WRITE, 16'hA800, 8'h77);
		send_access(CMD_READ, 16'hBFFF, 8'h00);
		drain();

		// no RAM: the window reads as unmapped
		load_banking(1'b0, 8'd2, RAM_CODE_NONE);
		send_access(CMD_READ, 16'hA000, 8'h00);
		send_access(CMD_WRITE, 16'hBFFF, 8'h3C);
		drain();

		for (int s = 0; s < BANK_SETUPS; s++) begin
			case (s)
				0:       load_banking(1'b0, 8'd2,   RAM_CODE_NONE);
				1:       load_banking(1'b1, 8'd128, RAM_CODE_128K);
				2:       load_banking(1'b0, 8'd32,  RAM_CODE_2K);
				3:       load_banking(1'b1, 8'd100, RAM_CODE_8K);
				4:       load_banking(1'b0, 8'd128, RAM_CODE_32K);
				5:       load_banking(1'b1, 8'd2,   RAM_CODE_32K);
				6:       load_banking(1'b1, 8'd77,  RAM_CODE_2K);
				default: load_banking(1'b0, 8'd128, RAM_CODE_8K);
			endcase
			repeat (RANDOM_ACCESSES / BANK_SETUPS) begin
				if (issued < RANDOM_ACCESSES / 3) begin
					gap_pct   = 27;
					stall_pct = 52;
				end else if (issued < 2 * RANDOM_ACCESSES / 3) begin
					gap_pct   = 52;
					stall_pct = 27;
				end else begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				random_access();
				issued++;
			end
			drain();
		end

		if (fail_count == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
